@@ rtl/vdu_pkg.sv @@
// shared types, codes and limits of the vector distance unit
package vdu_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [1:0] MET_L2  = 2'd0;
  localparam logic [1:0] MET_COS = 2'd1;
  localparam logic [1:0] MET_IP  = 2'd2;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_ZNORM  = 2'd1;
  localparam logic [1:0] ERR_METRIC = 2'd2;

  localparam logic [44:0]        DSQ_MAX  = {45{1'b1}};
  localparam logic [40:0]        NORM_MAX = {41{1'b1}};
  localparam logic signed [41:0] DOT_MAX  = {1'b0, {41{1'b1}}};
  localparam logic signed [41:0] DOT_MIN  = {1'b1, {41{1'b0}}};

  typedef struct packed {
    logic signed [15:0] elem_a;
    logic signed [15:0] elem_b;
    logic               last_element;
  } item_t;

  typedef struct packed {
    logic signed [41:0] distance;
    logic [1:0]         error_code;
  } result_t;

  typedef struct packed {
    logic [44:0]        dsq;
    logic signed [41:0] dot;
    logic [40:0]        na;
    logic [40:0]        nb;
    logic [1:0]         metric;
  } sums_t;

endpackage

@@ rtl/vdu_front.sv @@
// front end: per-pair products and saturating running sums
module vdu_front import vdu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       metric,
  input  logic             push,
  output logic             full,
  input  item_t            item,
  input  logic [QCntW-1:0] q_count,
  output logic             q_push,
  output sums_t            q_data
);

  logic               accept;
  logic signed [16:0] diff;
  logic [15:0]        ad, aa, ab;
  logic               s1_valid, s1_last;
  logic [31:0]        s1_dsq;
  logic signed [31:0] s1_dot;
  logic [30:0]        s1_na, s1_nb;
  logic [44:0]        acc_dsq;
  logic signed [41:0] acc_dot;
  logic [40:0]        acc_na, acc_nb;
  logic [45:0]        dsq_sum;
  logic [41:0]        na_sum, nb_sum;
  logic signed [42:0] dot_sum;
  logic [44:0]        dsq_sat;
  logic signed [41:0] dot_sat;
  logic [40:0]        na_sat, nb_sat;

  // one pending last pair in stage 1 may still land in the queue
  assign full   = q_count >= QCntW'(QDepth - 1);
  assign accept = push && !full;

  assign diff = {item.elem_a[15], item.elem_a} - {item.elem_b[15], item.elem_b};
  assign ad   = diff[16] ? 16'(-diff) : diff[15:0];
  assign aa   = item.elem_a[15] ? 16'(-item.elem_a) : item.elem_a;
  assign ab   = item.elem_b[15] ? 16'(-item.elem_b) : item.elem_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_last <= item.last_element;
      s1_dsq  <= ad * ad;
      s1_dot  <= item.elem_a * item.elem_b;
      s1_na   <= 31'(aa * aa);
      s1_nb   <= 31'(ab * ab);
    end
  end

  assign dsq_sum = {1'b0, acc_dsq} + 46'(s1_dsq);
  assign na_sum  = {1'b0, acc_na} + 42'(s1_na);
  assign nb_sum  = {1'b0, acc_nb} + 42'(s1_nb);
  assign dot_sum = 43'(acc_dot) + 43'(s1_dot);

  assign dsq_sat = dsq_sum[45] ? DSQ_MAX : dsq_sum[44:0];
  assign na_sat  = na_sum[41] ? NORM_MAX : na_sum[40:0];
  assign nb_sat  = nb_sum[41] ? NORM_MAX : nb_sum[40:0];
  always_comb begin
    if (dot_sum[42] != dot_sum[41]) begin
      dot_sat = dot_sum[42] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_sat = dot_sum[41:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_dsq <= '0;
      acc_dot <= '0;
      acc_na  <= '0;
      acc_nb  <= '0;
    end else if (s1_valid) begin
      acc_dsq <= s1_last ? '0 : dsq_sat;
      acc_dot <= s1_last ? '0 : dot_sat;
      acc_na  <= s1_last ? '0 : na_sat;
      acc_nb  <= s1_last ? '0 : nb_sat;
    end
  end

  assign q_push = s1_valid && s1_last;
  assign q_data = '{dsq: dsq_sat, dot: dot_sat, na: na_sat, nb: nb_sat, metric: metric};

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_count < QCntW'(QDepth))
    else $error("front pushed into a full queue");

endmodule

@@ rtl/vdu_queue.sv @@
// short queue of finished vector sums between front and back
module vdu_queue import vdu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sums_t            wdata,
  input  logic             rd,
  output logic             valid,
  output sums_t            rdata,
  output logic [QCntW-1:0] count
);

  sums_t            mem [QDepth];
  logic [QPtrW-1:0] wptr, rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + QCntW'(wr) - QCntW'(rd);
    end
    if (wr) mem[wptr] <= wdata;
  end

  assign valid = count != '0;
  assign rdata = mem[rptr];

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> count != '0)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count out of range");

endmodule

@@ rtl/vdu_back.sv @@
// back end: square root, divide and result formatting sequencer
module vdu_back import vdu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  sums_t   q_data,
  output logic    q_rd,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQA  = 3'd1;
  localparam logic [2:0] ST_SQB  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]         st;
  logic [6:0]         cnt;
  logic [1:0]         met;
  logic [40:0]        nb;
  logic               neg;
  logic [41:0]        dv;
  logic [63:0]        sq_v, sq_res, sq_bit;
  logic [63:0]        sq_sum, sq_v_next, sq_res_next;
  logic               sq_ge;
  logic [30:0]        sa, sb;
  logic [61:0]        den, rem;
  logic [62:0]        trial;
  logic               div_ge;
  logic [16:0]        q;
  logic               sticky;
  logic [16:0]        qc;
  logic signed [41:0] dist_val;
  logic [1:0]         err;
  logic               out_valid;

  // one restoring square root step
  assign sq_sum      = sq_res + sq_bit;
  assign sq_ge       = sq_v >= sq_sum;
  assign sq_v_next   = sq_ge ? sq_v - sq_sum : sq_v;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  // one restoring divide step
  assign trial  = {rem, dv[41]};
  assign div_ge = trial >= {1'b0, den};
  assign qc     = (sticky || q > 17'd65536) ? 17'd65536 : q;

  assign q_rd = (st == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (q_valid) begin
            met      <= q_data.metric;
            nb       <= q_data.nb;
            neg      <= q_data.dot[41];
            dv       <= q_data.dot[41] ? 42'(-q_data.dot) : q_data.dot;
            dist_val <= '0;
            err      <= ERR_OK;
            sq_res   <= '0;
            sq_bit   <= 64'd1 << 62;
            cnt      <= 7'd31;
            case (q_data.metric)
              MET_L2: begin
                sq_v <= 64'(q_data.dsq);
                st   <= ST_SQA;
              end
              MET_COS: begin
                sq_v <= {3'b0, q_data.na, 20'b0};
                if (q_data.na == '0 || q_data.nb == '0) begin
                  err <= ERR_ZNORM;
                  st  <= ST_OUT;
                end else begin
                  st  <= ST_SQA;
                end
              end
              MET_IP: begin
                dist_val <= (q_data.dot == DOT_MIN) ? DOT_MAX : -q_data.dot;
                st       <= ST_OUT;
              end
              default: begin
                err <= ERR_METRIC;
                st  <= ST_OUT;
              end
            endcase
          end
        end
        ST_SQA, ST_SQB: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            if (st == ST_SQA && met == MET_L2) begin
              dist_val <= 42'(sq_res_next);
              st       <= ST_OUT;
            end else if (st == ST_SQA) begin
              sa     <= sq_res_next[30:0];
              sq_v   <= {3'b0, nb, 20'b0};
              sq_res <= '0;
              sq_bit <= 64'd1 << 62;
              cnt    <= 7'd31;
              st     <= ST_SQB;
            end else begin
              sb <= sq_res_next[30:0];
              st <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          den    <= sa * sb;
          rem    <= '0;
          q      <= '0;
          sticky <= 1'b0;
          cnt    <= 7'd77;
          st     <= ST_DIV;
        end
        ST_DIV: begin
          rem    <= div_ge ? 62'(trial - {1'b0, den}) : trial[61:0];
          dv     <= dv << 1;
          sticky <= sticky | q[16];
          q      <= {q[15:0], div_ge};
          cnt    <= cnt - 1'b1;
          if (cnt == '0) st <= ST_FIN;
        end
        ST_FIN: begin
          dist_val <= neg ? 42'(17'd65536) + 42'(qc) : 42'(17'd65536) - 42'(qc);
          st       <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || pop) begin
            result    <= '{distance: dist_val, error_code: err};
            out_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign empty = !out_valid;

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    st == ST_DIV |-> den != '0)
    else $error("divide started with zero divisor");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(result))
    else $error("waiting result lost or changed");

endmodule

@@ rtl/vector_distance_unit.sv @@
// top level of the vector distance unit: config register, front, queue, back
//
// element pairs (signed q8.8) stream in through a queue-style port at one
// pair per cycle while full is low; products and saturating running sums
// are formed in a two stage front end, and the pair flagged last hands the
// finished sums to a four-entry queue. the back end works one vector at a
// time: l2 takes a 32-step bit-serial square root, cosine two square roots,
// a multiply and a 78-step restoring divide; inner product and errors go
// straight to output. the front keeps streaming while the back works, so
// long vectors run at one pair per cycle while the queue has room; short
// vectors are paced by the back end latency. metric is register 0 at byte
// address 0 and is latched with each vector when its last pair is summed
module vector_distance_unit import vdu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // element pair transactions
  input  logic        push,
  output logic        full,
  input  item_t       item,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output result_t     result
);

  logic [1:0]       metric;
  logic             q_push, q_rd, q_valid;
  sums_t            q_wdata, q_rdata;
  logic [QCntW-1:0] q_count;

  // register writes complete in the access phase, no wait states
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      metric <= MET_L2;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      metric <= pwdata[1:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {30'b0, metric} : '0;

  vdu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .metric  (metric),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  vdu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_rd),
    .valid (q_valid),
    .rdata (q_rdata),
    .count (q_count)
  );

  vdu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // the queue must never wrap past its depth
  a_full_guard: assert property (@(posedge clk) disable iff (rst)
    push && !full |-> q_count < QCntW'(QDepth - 1))
    else $error("pair accepted without queue room");

endmodule
